### hw/rtl/anchor_box_detection_decoder_top_defines.svh
// ----------------------------------------------------------------------------
// anchor box decoder assertion macros
// concurrent assertion shorthands clocked on clk_i, disabled during reset
// ----------------------------------------------------------------------------
`ifndef ANCHOR_BOX_DETECTION_DECODER_TOP_DEFINES_SVH
`define ANCHOR_BOX_DETECTION_DECODER_TOP_DEFINES_SVH

// same-cycle implication
`define ABDD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("abdd assertion failed");

// next-cycle implication
`define ABDD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("abdd assertion failed");

`endif

### hw/rtl/abdd_pkg.sv
// ----------------------------------------------------------------------------
// abdd_pkg
// shared types, register indexes and the exp table of the box decoder
// ----------------------------------------------------------------------------
package abdd_pkg;

  localparam int unsigned DEF_NET_WIDTH   = 416;
  localparam int unsigned DEF_NET_HEIGHT  = 416;
  localparam int unsigned DEF_ANCHORS     = 3;
  localparam int unsigned DEF_CLASS_COUNT = 80;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 60;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMG_W     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMG_H     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_W    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_H    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ANCHORS   = 3'd5;

  // divider operand widths cover the largest edge numerator and denominator
  localparam int unsigned DIV_NUM_W = 61;
  localparam int unsigned DIV_DEN_W = 36;

  localparam logic [14:0] LOG2E_Q14 = 15'd23637;

  typedef struct packed {
    logic [15:0] threshold;
    logic [12:0] img_w;
    logic [12:0] img_h;
    logic [7:0]  grid_w;
    logic [7:0]  grid_h;
    logic [59:0] anchors;
  } cfg_t;

  typedef struct packed {
    logic [6:0]         col;
    logic [6:0]         row;
    logic [1:0]         slot;
    logic [15:0]        x_off;
    logic [15:0]        y_off;
    logic signed [15:0] log_w;
    logic signed [15:0] log_h;
    logic [7:0]         class_id;
    logic [15:0]        score;
  } job_t;

  typedef struct packed {
    logic [11:0] left;
    logic [11:0] top;
    logic [11:0] box_width;
    logic [11:0] box_height;
    logic [7:0]  class_id;
    logic [15:0] score;
  } res_t;

  // 2^(i/16) in Q16
  function automatic logic [17:0] pow2_entry(input logic [4:0] i);
    logic [17:0] v;
    unique case (i)
      5'd0:    v = 18'd65536;
      5'd1:    v = 18'd68438;
      5'd2:    v = 18'd71468;
      5'd3:    v = 18'd74632;
      5'd4:    v = 18'd77936;
      5'd5:    v = 18'd81386;
      5'd6:    v = 18'd84990;
      5'd7:    v = 18'd88752;
      5'd8:    v = 18'd92682;
      5'd9:    v = 18'd96785;
      5'd10:   v = 18'd101070;
      5'd11:   v = 18'd105545;
      5'd12:   v = 18'd110218;
      5'd13:   v = 18'd115098;
      5'd14:   v = 18'd120194;
      5'd15:   v = 18'd125515;
      default: v = 18'd131072;
    endcase
    return v;
  endfunction

endpackage

### hw/rtl/anchor_box_detection_decoder_top.sv
// ----------------------------------------------------------------------------
// anchor_box_detection_decoder_top
// anchor box decoder: per-class argmax front, queued box decode back end
// ----------------------------------------------------------------------------
// class score items are taken one per cycle while the job queue has room
// a closing item is queued as a job, and its box goes through the back end to the result queue
// the back end decodes one box at a time, using the shared bit-serial divider
// (five divisions per box); closes that come faster wait in the job queue
// reset clears the argmax state, both queues and loads the register defaults
// ----------------------------------------------------------------------------
module anchor_box_detection_decoder_top import abdd_pkg::*; #(
  parameter int unsigned NET_WIDTH   = DEF_NET_WIDTH,
  parameter int unsigned NET_HEIGHT  = DEF_NET_HEIGHT,
  parameter int unsigned ANCHORS     = DEF_ANCHORS,
  parameter int unsigned CLASS_COUNT = DEF_CLASS_COUNT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  push,
  output logic                  full,
  input  logic [6:0]            col_i,
  input  logic [6:0]            row_i,
  input  logic [1:0]            anchor_slot_i,
  input  logic [15:0]           x_offset_i,
  input  logic [15:0]           y_offset_i,
  input  logic signed [15:0]    log_w_i,
  input  logic signed [15:0]    log_h_i,
  input  logic [15:0]           objectness_i,
  input  logic [15:0]           class_prob_i,
  input  logic [7:0]            class_index_i,
  input  logic                  last_class_i,
  output logic                  empty,
  input  logic                  pop,
  output logic [11:0]           left_o,
  output logic [11:0]           top_o,
  output logic [11:0]           box_width_o,
  output logic [11:0]           box_height_o,
  output logic [7:0]            class_id_o,
  output logic [15:0]           score_o
);

  cfg_t cfg_q;
  logic cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold <= 16'd32768;
      cfg_q.img_w     <= 13'd416;
      cfg_q.img_h     <= 13'd416;
      cfg_q.grid_w    <= 8'd13;
      cfg_q.grid_h    <= 8'd13;
      cfg_q.anchors   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        REG_THRESHOLD: cfg_q.threshold <= cfg_data_i[15:0];
        REG_IMG_W:     cfg_q.img_w     <= cfg_data_i[12:0];
        REG_IMG_H:     cfg_q.img_h     <= cfg_data_i[12:0];
        REG_GRID_W:    cfg_q.grid_w    <= cfg_data_i[7:0];
        REG_GRID_H:    cfg_q.grid_h    <= cfg_data_i[7:0];
        REG_ANCHORS:   cfg_q.anchors   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  logic accept;
  logic job_push, job_full, job_empty, job_pop;
  job_t job_in, job_out;
  logic res_push, res_full;
  res_t res_in, res_out;

  assign full   = job_full;
  assign accept = push && !job_full;

  abdd_front #(
    .CLASS_COUNT(CLASS_COUNT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .col_i        (col_i),
    .row_i        (row_i),
    .anchor_slot_i(anchor_slot_i),
    .x_offset_i   (x_offset_i),
    .y_offset_i   (y_offset_i),
    .log_w_i      (log_w_i),
    .log_h_i      (log_h_i),
    .objectness_i (objectness_i),
    .class_prob_i (class_prob_i),
    .class_index_i(class_index_i),
    .last_class_i (last_class_i),
    .threshold_i  (cfg_q.threshold),
    .job_push_o   (job_push),
    .job_o        (job_in)
  );

  abdd_fifo #(
    .WIDTH($bits(job_t)),
    .DEPTH(2)
  ) u_job_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (job_push),
    .wdata_i(job_in),
    .full_o (job_full),
    .rd_i   (job_pop),
    .rdata_o(job_out),
    .empty_o(job_empty)
  );

  abdd_back #(
    .NET_WIDTH (NET_WIDTH),
    .NET_HEIGHT(NET_HEIGHT),
    .ANCHORS   (ANCHORS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .job_valid_i(!job_empty),
    .job_i      (job_out),
    .job_pop_o  (job_pop),
    .res_room_i (!res_full),
    .res_push_o (res_push),
    .res_o      (res_in)
  );

  abdd_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(2)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (res_push),
    .wdata_i(res_in),
    .full_o (res_full),
    .rd_i   (pop),
    .rdata_o(res_out),
    .empty_o(empty)
  );

  assign left_o       = res_out.left;
  assign top_o        = res_out.top;
  assign box_width_o  = res_out.box_width;
  assign box_height_o = res_out.box_height;
  assign class_id_o   = res_out.class_id;
  assign score_o      = res_out.score;

endmodule

### hw/rtl/abdd_fifo.sv
// ----------------------------------------------------------------------------
// abdd_fifo
// small register queue used between front and back and on the result side
// ----------------------------------------------------------------------------
module abdd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             rd_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_wr, do_rd;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/abdd_front.sv
// ----------------------------------------------------------------------------
// abdd_front
// running argmax over class scores, closes an anchor and queues a decode job if it passes the threshold
// ----------------------------------------------------------------------------
module abdd_front import abdd_pkg::*; #(
  parameter int unsigned CLASS_COUNT = DEF_CLASS_COUNT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [6:0]         col_i,
  input  logic [6:0]         row_i,
  input  logic [1:0]         anchor_slot_i,
  input  logic [15:0]        x_offset_i,
  input  logic [15:0]        y_offset_i,
  input  logic signed [15:0] log_w_i,
  input  logic signed [15:0] log_h_i,
  input  logic [15:0]        objectness_i,
  input  logic [15:0]        class_prob_i,
  input  logic [7:0]         class_index_i,
  input  logic               last_class_i,
  input  logic [15:0]        threshold_i,
  output logic               job_push_o,
  output job_t               job_o
);

  logic [15:0] best_q, best_d;
  logic [7:0]  cls_q, cls_d;
  logic        open_q, open_d;
  logic [31:0] prod;
  logic [15:0] combined, best_n;
  logic [7:0]  cls_n;
  logic        ci_ok, take, open_n;

  assign prod     = 32'(objectness_i) * 32'(class_prob_i);
  assign combined = prod[31:16];
  assign ci_ok    = ({1'b0, class_index_i} < 9'(CLASS_COUNT));
  // first maximum wins, so only a strictly greater score replaces it
  assign take     = ci_ok && (!open_q || (combined > best_q));
  assign best_n   = take ? combined : best_q;
  assign cls_n    = take ? class_index_i : cls_q;
  assign open_n   = open_q || ci_ok;

  always_comb begin
    best_d = best_q;
    cls_d  = cls_q;
    open_d = open_q;
    if (accept_i) begin
      if (last_class_i) begin
        best_d = '0;
        cls_d  = '0;
        open_d = 1'b0;
      end else begin
        best_d = best_n;
        cls_d  = cls_n;
        open_d = open_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q <= '0;
      cls_q  <= '0;
      open_q <= 1'b0;
    end else begin
      best_q <= best_d;
      cls_q  <= cls_d;
      open_q <= open_d;
    end
  end

  assign job_push_o = accept_i && last_class_i && open_n
                   && (objectness_i >= threshold_i) && (best_n >= threshold_i);

  always_comb begin
    job_o.col      = col_i;
    job_o.row      = row_i;
    job_o.slot     = anchor_slot_i;
    job_o.x_off    = x_offset_i;
    job_o.y_off    = y_offset_i;
    job_o.log_w    = log_w_i;
    job_o.log_h    = log_h_i;
    job_o.class_id = cls_n;
    job_o.score    = best_n;
  end

endmodule

### hw/rtl/abdd_div.sv
// ----------------------------------------------------------------------------
// abdd_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module abdd_div import abdd_pkg::*; #(
  parameter int unsigned NUM_W = DIV_NUM_W,
  parameter int unsigned DEN_W = DIV_DEN_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem_q;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W:0]   trial, diff;
  logic             fits;

  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= num_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_q <= {quo_q[NUM_W-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

### hw/rtl/abdd_back.sv
// ----------------------------------------------------------------------------
// abdd_back
// box decode sequencer: letterbox size, exp, anchor scaling, edges, clamping
// ----------------------------------------------------------------------------
module abdd_back import abdd_pkg::*; #(
  parameter int unsigned NET_WIDTH  = DEF_NET_WIDTH,
  parameter int unsigned NET_HEIGHT = DEF_NET_HEIGHT,
  parameter int unsigned ANCHORS    = DEF_ANCHORS
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic job_valid_i,
  input  job_t job_i,
  output logic job_pop_o,
  input  logic res_room_i,
  output logic res_push_o,
  output res_t res_o
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_SIZE      = 4'd1;
  localparam logic [3:0] S_SIZE_WAIT = 4'd2;
  localparam logic [3:0] S_EXP_MUL   = 4'd3;
  localparam logic [3:0] S_EXP_TAB   = 4'd4;
  localparam logic [3:0] S_EXP_SHIFT = 4'd5;
  localparam logic [3:0] S_HALF      = 4'd6;
  localparam logic [3:0] S_SPAN      = 4'd7;
  localparam logic [3:0] S_SUM       = 4'd8;
  localparam logic [3:0] S_PROD      = 4'd9;
  localparam logic [3:0] S_DIV       = 4'd10;
  localparam logic [3:0] S_DIV_WAIT  = 4'd11;
  localparam logic [3:0] S_EDGE      = 4'd12;
  localparam logic [3:0] S_DONE      = 4'd13;

  localparam logic [11:0] NET_W_L = 12'(NET_WIDTH);
  localparam logic [11:0] NET_H_L = 12'(NET_HEIGHT);
  localparam logic [1:0]  SLOT_MAX = 2'(ANCHORS - 1);

  logic [3:0]  state_q, state_d;
  job_t        job_q;
  logic        ax_q, hi_q, cmp_q, neg_q;
  logic [11:0] new_w_q, new_h_q;
  logic [30:0] y_q;
  logic [17:0] mant_q;
  logic [4:0]  kraw_q;
  logic [28:0] e_q;
  logic signed [37:0] a_q;
  logic [38:0] ea_q;
  logic [46:0] half_q;
  logic [35:0] den_q;
  logic signed [48:0] sum_q;
  logic signed [61:0] prod_q;
  logic signed [45:0] lo_q, hi_val_q;
  res_t        res_q;

  // configuration with open cases folded in
  logic [12:0] img_w, img_h;
  logic [7:0]  grid_w, grid_h;
  logic [1:0]  slot_eff;
  logic [9:0]  anc_w, anc_h;

  always_comb begin
    img_w  = (cfg_i.img_w == '0) ? 13'd1 : ((cfg_i.img_w > 13'd4096) ? 13'd4096 : cfg_i.img_w);
    img_h  = (cfg_i.img_h == '0) ? 13'd1 : ((cfg_i.img_h > 13'd4096) ? 13'd4096 : cfg_i.img_h);
    grid_w = (cfg_i.grid_w == '0) ? 8'd1 : cfg_i.grid_w;
    grid_h = (cfg_i.grid_h == '0) ? 8'd1 : cfg_i.grid_h;
    slot_eff = (job_q.slot > SLOT_MAX) ? SLOT_MAX : job_q.slot;
    unique case (slot_eff)
      2'd0: begin
        anc_w = cfg_i.anchors[9:0];
        anc_h = cfg_i.anchors[19:10];
      end
      2'd1: begin
        anc_w = cfg_i.anchors[29:20];
        anc_h = cfg_i.anchors[39:30];
      end
      default: begin
        anc_w = cfg_i.anchors[49:40];
        anc_h = cfg_i.anchors[59:50];
      end
    endcase
  end

  // current axis operands
  logic [6:0]         cell_pos;
  logic [15:0]        off;
  logic signed [15:0] logv;
  logic [7:0]         cells;
  logic [11:0]        net, newn;
  logic [9:0]         anc;
  logic [12:0]        img;

  always_comb begin
    cell_pos = ax_q ? job_q.row   : job_q.col;
    off      = ax_q ? job_q.y_off : job_q.x_off;
    logv     = ax_q ? job_q.log_h : job_q.log_w;
    cells    = ax_q ? grid_h      : grid_w;
    net      = ax_q ? NET_H_L     : NET_W_L;
    newn     = ax_q ? new_h_q     : new_w_q;
    anc      = ax_q ? anc_h       : anc_w;
    img      = ax_q ? img_h       : img_w;
  end

  // letterbox size compare
  logic [24:0] nw_h, nh_w;
  assign nw_h = 25'(NET_W_L) * 25'(img_h);
  assign nh_w = 25'(NET_H_L) * 25'(img_w);

  // exp stages
  logic signed [31:0] y_full;
  logic [17:0] t0, t1, mant_d;
  logic [33:0] interp;
  logic [28:0] e_d;
  assign y_full = 32'(logv) * $signed({17'b0, LOG2E_Q14}) + (32'sd1 <<< 30);
  assign t0     = pow2_entry({1'b0, y_q[25:22]});
  assign t1     = pow2_entry(5'({1'b0, y_q[25:22]} + 5'd1));
  assign interp = 34'(t1 - t0) * 34'(y_q[21:6]);
  assign mant_d = t0 + 18'(interp >> 16);
  assign e_d    = (kraw_q >= 5'd16) ? (29'(mant_q) << (kraw_q - 5'd16))
                                    : (29'(mant_q) >> (5'd16 - kraw_q));

  // cell center term over the common denominator
  logic [35:0] t_pos, t_neg;
  logic [19:0] shrink;
  assign t_pos  = (36'({cell_pos, off}) * 36'(net)) << 1;
  assign shrink = 20'(net - newn) * 20'(cells);
  assign t_neg  = 36'(shrink) << 16;

  logic [19:0] den_prod;
  assign den_prod = 20'(cells) * 20'(newn);

  // divider
  logic                 div_start, div_done;
  logic [DIV_NUM_W-1:0] div_num, div_quot;
  logic [DIV_DEN_W-1:0] div_den;
  logic signed [61:0]   prod_abs;
  logic [11:0]          size_q;

  assign prod_abs = prod_q[61] ? -prod_q : prod_q;
  assign size_q   = (div_quot[11:0] == '0) ? 12'd1 : div_quot[11:0];

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    if (state_q == S_SIZE) begin
      div_start = 1'b1;
      div_num   = (nw_h < nh_w) ? DIV_NUM_W'(nw_h) : DIV_NUM_W'(nh_w);
      div_den   = (nw_h < nh_w) ? DIV_DEN_W'(img_w) : DIV_DEN_W'(img_h);
    end else if (state_q == S_DIV) begin
      div_start = 1'b1;
      div_num   = prod_abs[DIV_NUM_W-1:0];
      div_den   = den_q;
    end
  end

  abdd_div #(
    .NUM_W(DIV_NUM_W),
    .DEN_W(DIV_DEN_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  logic signed [45:0] q_signed;
  assign q_signed = neg_q ? -$signed({1'b0, div_quot[44:0]}) : $signed({1'b0, div_quot[44:0]});

  // edge clamping
  logic signed [45:0] lo_c, hi_c, img_m1;
  logic [11:0]        len, lo_out;
  always_comb begin
    img_m1 = 46'(img) - 46'sd1;
    lo_c   = (lo_q < 0) ? 46'sd0 : lo_q;
    hi_c   = (hi_val_q > img_m1) ? img_m1 : hi_val_q;
    len    = (hi_c > lo_c) ? 12'(hi_c - lo_c) : 12'd0;
    lo_out = (lo_c > 46'sd4095) ? 12'd4095 : lo_c[11:0];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:      if (job_valid_i && res_room_i) state_d = S_SIZE;
      S_SIZE:      state_d = S_SIZE_WAIT;
      S_SIZE_WAIT: if (div_done) state_d = S_EXP_MUL;
      S_EXP_MUL:   state_d = S_EXP_TAB;
      S_EXP_TAB:   state_d = S_EXP_SHIFT;
      S_EXP_SHIFT: state_d = S_HALF;
      S_HALF:      state_d = S_SPAN;
      S_SPAN:      state_d = S_SUM;
      S_SUM:       state_d = S_PROD;
      S_PROD:      state_d = S_DIV;
      S_DIV:       state_d = S_DIV_WAIT;
      S_DIV_WAIT:  if (div_done) state_d = hi_q ? S_EDGE : S_SUM;
      S_EDGE:      state_d = ax_q ? S_DONE : S_EXP_MUL;
      S_DONE:      state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ax_q    <= 1'b0;
      hi_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_IDLE) begin
        ax_q <= 1'b0;
        hi_q <= 1'b0;
      end else if (state_q == S_DIV_WAIT && div_done) begin
        hi_q <= 1'b1;
      end else if (state_q == S_EDGE) begin
        ax_q <= 1'b1;
        hi_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        job_q <= job_i;
      end
      S_SIZE: begin
        cmp_q <= (nw_h < nh_w);
      end
      S_SIZE_WAIT: begin
        if (div_done) begin
          new_w_q <= cmp_q ? NET_W_L : size_q;
          new_h_q <= cmp_q ? size_q : NET_H_L;
        end
      end
      S_EXP_MUL: begin
        y_q <= y_full[30:0];
      end
      S_EXP_TAB: begin
        mant_q <= mant_d;
        kraw_q <= y_q[30:26];
      end
      S_EXP_SHIFT: begin
        e_q <= e_d;
        a_q <= $signed({2'b0, t_pos}) - $signed({2'b0, t_neg});
      end
      S_HALF: begin
        ea_q  <= 39'(e_q) * 39'(anc);
        den_q <= 36'(den_prod) << 17;
      end
      S_SPAN: begin
        half_q <= 47'(ea_q) * 47'(cells);
      end
      S_SUM: begin
        sum_q <= hi_q ? (49'(a_q) + $signed({2'b0, half_q}))
                      : (49'(a_q) - $signed({2'b0, half_q}));
      end
      S_PROD: begin
        prod_q <= 62'(sum_q) * $signed({49'b0, img});
      end
      S_DIV: begin
        neg_q <= prod_q[61];
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          if (hi_q) begin
            hi_val_q <= q_signed;
          end else begin
            lo_q <= q_signed;
          end
        end
      end
      S_EDGE: begin
        if (ax_q) begin
          res_q.top        <= lo_out;
          res_q.box_height <= len;
        end else begin
          res_q.left      <= lo_out;
          res_q.box_width <= len;
        end
        res_q.class_id <= job_q.class_id;
        res_q.score    <= job_q.score;
      end
      default: begin
      end
    endcase
  end

  assign job_pop_o  = (state_q == S_IDLE) && job_valid_i && res_room_i;
  assign res_push_o = (state_q == S_DONE);
  assign res_o      = res_q;

endmodule

### hw/rtl/abdd_checker.sv
// ----------------------------------------------------------------------------
// abdd_checker
// port-level checks on the result side of the box decoder
// ----------------------------------------------------------------------------
`include "anchor_box_detection_decoder_top_defines.svh"

module abdd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [11:0] left_o,
  input logic [11:0] top_o,
  input logic [11:0] box_width_o,
  input logic [11:0] box_height_o,
  input logic [7:0]  class_id_o,
  input logic [15:0] score_o
);

  // a waiting item stays until popped
  `ABDD_ASSERT_NEXT(a_res_held, !empty && !pop, !empty)
  `ABDD_ASSERT_NEXT(a_res_stable, !empty && !pop, $stable({left_o, class_id_o, score_o}))

  // right and bottom edges never pass coordinate 4095
  `ABDD_ASSERT_IMPL(a_right_in_image, !empty, (13'(left_o) + 13'(box_width_o)) <= 13'd4095)
  `ABDD_ASSERT_IMPL(a_bottom_in_image, !empty, (13'(top_o) + 13'(box_height_o)) <= 13'd4095)

endmodule

bind anchor_box_detection_decoder_top abdd_checker u_abdd_checker (.*);
